[rtl/pbw_pkg.sv]
// Shared types and constants of the planar blitter word engine.
// Used by pbw_walk, pbw_word_alu and planar_bitblt_word_engine.
package pbw_pkg;

    localparam int WORD_BITS = 16;
    localparam int DEF_MAX_WIDTH = 4096;
    localparam int DEF_MAX_HEIGHT = 4096;
    localparam int DEF_MAX_PLANES = 8;

    localparam int ADDR_W = 5;
    localparam int DATA_W = 32;

    // Register indexes (byte address = 4 * index)
    localparam logic [2:0] REG_ROP = 3'd0;
    localparam logic [2:0] REG_MSB_FIRST = 3'd1;
    localparam logic [2:0] REG_SRC_OFFSET = 3'd2;
    localparam logic [2:0] REG_DST_OFFSET = 3'd3;
    localparam logic [2:0] REG_WIDTH = 3'd4;
    localparam logic [2:0] REG_HEIGHT = 3'd5;
    localparam logic [2:0] REG_PLANES = 3'd6;

    // Raster op codes
    localparam logic [2:0] ROP_COPY = 3'd0;
    localparam logic [2:0] ROP_NOT = 3'd1;
    localparam logic [2:0] ROP_AND = 3'd2;
    localparam logic [2:0] ROP_AND_NOT = 3'd3;
    localparam logic [2:0] ROP_OR = 3'd4;
    localparam logic [2:0] ROP_OR_NOT = 3'd5;
    localparam logic [2:0] ROP_XOR = 3'd6;
    localparam logic [2:0] ROP_XNOR = 3'd7;

    typedef struct packed {
        logic [2:0]  rop;
        logic        msb_first;
        logic [3:0]  src_offset;
        logic [3:0]  dst_offset;
        logic [12:0] width;
        logic [12:0] height;
        logic [3:0]  planes;
    } cfg_t;

    // Position of one word within the blit
    typedef struct packed {
        logic [3:0] start;     // first pixel covered
        logic [4:0] stop;      // one past the last pixel covered
        logic       last_word;
        logic       blit_end;
    } pos_t;

endpackage

[rtl/planar_bitblt_word_engine.sv]
// Top level of the planar blitter word engine: APB register file, input
// stage, walker, word datapath and output register. Depends on pbw_pkg,
// pbw_walk and pbw_word_alu.
//
//  port group   dir  content (low bits first)
//  s_*          in   tdata: src_word, src_next_word, dest_word
//  m_*          out  tdata: new_dest_word; tlast: line_end; tuser: blit_end
//  p*           in   APB register access, 7 registers at 4*index
//
// One word per cycle while m_tready is high; a word passes the input register,
// then the datapath into the output register. Walker counters advance on input
// acceptance. Reset (aresetn low, synchronous) clears counters, valids and the
// configuration registers to their defaults; s_tready is low while in reset. A stalled
// output holds its word; the input register keeps accepting until it is full.
module planar_bitblt_word_engine #(
    parameter int MAX_WIDTH = pbw_pkg::DEF_MAX_WIDTH,
    parameter int MAX_HEIGHT = pbw_pkg::DEF_MAX_HEIGHT,
    parameter int MAX_PLANES = pbw_pkg::DEF_MAX_PLANES
) (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        s_tvalid,
    output logic                        s_tready,
    input  logic [47:0]                 s_tdata,   // src_word, src_next_word, dest_word
    output logic                        m_tvalid,
    input  logic                        m_tready,
    output logic [15:0]                 m_tdata,   // new_dest_word
    output logic                        m_tlast,   // line_end
    output logic                        m_tuser,   // blit_end
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [pbw_pkg::ADDR_W-1:0]  paddr,
    input  logic [pbw_pkg::DATA_W-1:0]  pwdata,
    output logic [pbw_pkg::DATA_W-1:0]  prdata,
    output logic                        pready
);
    pbw_pkg::cfg_t cfg_reg;
    logic [2:0]    reg_idx;
    logic          wr_en;

    logic          v1_reg, v2_reg;
    logic [47:0]   data1_reg;
    pbw_pkg::pos_t pos1_reg, pos_now;
    logic [15:0]   word2_reg, alu_out;
    logic          last2_reg, end2_reg;
    logic          adv2, accept;

    assign pready = 1'b1;
    assign reg_idx = paddr[4:2];
    assign wr_en = psel && penable && pwrite;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.rop <= pbw_pkg::ROP_COPY;
            cfg_reg.msb_first <= 1'b1;
            cfg_reg.src_offset <= '0;
            cfg_reg.dst_offset <= '0;
            cfg_reg.width <= 13'd1;
            cfg_reg.height <= 13'd1;
            cfg_reg.planes <= 4'd1;
        end else if (wr_en) begin
            unique case (reg_idx)
                pbw_pkg::REG_ROP:        cfg_reg.rop <= pwdata[2:0];
                pbw_pkg::REG_MSB_FIRST:  cfg_reg.msb_first <= pwdata[0];
                pbw_pkg::REG_SRC_OFFSET: cfg_reg.src_offset <= pwdata[3:0];
                pbw_pkg::REG_DST_OFFSET: cfg_reg.dst_offset <= pwdata[3:0];
                pbw_pkg::REG_WIDTH:      cfg_reg.width <= pwdata[12:0];
                pbw_pkg::REG_HEIGHT:     cfg_reg.height <= pwdata[12:0];
                pbw_pkg::REG_PLANES:     cfg_reg.planes <= pwdata[3:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (reg_idx)
            pbw_pkg::REG_ROP:        prdata = 32'(cfg_reg.rop);
            pbw_pkg::REG_MSB_FIRST:  prdata = 32'(cfg_reg.msb_first);
            pbw_pkg::REG_SRC_OFFSET: prdata = 32'(cfg_reg.src_offset);
            pbw_pkg::REG_DST_OFFSET: prdata = 32'(cfg_reg.dst_offset);
            pbw_pkg::REG_WIDTH:      prdata = 32'(cfg_reg.width);
            pbw_pkg::REG_HEIGHT:     prdata = 32'(cfg_reg.height);
            pbw_pkg::REG_PLANES:     prdata = 32'(cfg_reg.planes);
            default:                 prdata = '0;
        endcase
    end

    // Two-stage pipeline; each stage loads when the one after it can move
    assign adv2 = !v2_reg || m_tready;
    assign s_tready = aresetn && (!v1_reg || adv2);
    assign accept = s_tvalid && s_tready;

    pbw_walk #(
        .MAX_WIDTH (MAX_WIDTH),
        .MAX_HEIGHT(MAX_HEIGHT),
        .MAX_PLANES(MAX_PLANES)
    ) u_walk (
        .aclk   (aclk),
        .aresetn(aresetn),
        .cfg    (cfg_reg),
        .step   (accept),
        .pos    (pos_now)
    );

    pbw_word_alu u_alu (
        .msb_first    (cfg_reg.msb_first),
        .rop          (cfg_reg.rop),
        .src_offset   (cfg_reg.src_offset),
        .dst_offset   (cfg_reg.dst_offset),
        .start        (pos1_reg.start),
        .stop         (pos1_reg.stop),
        .src_word     (data1_reg[15:0]),
        .src_next_word(data1_reg[31:16]),
        .dest_word    (data1_reg[47:32]),
        .new_dest_word(alu_out)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
        end else begin
            if (accept) begin
                v1_reg <= 1'b1;
            end else if (adv2) begin
                v1_reg <= 1'b0;
            end
            if (adv2) begin
                v2_reg <= v1_reg;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            data1_reg <= s_tdata;
            pos1_reg <= pos_now;
        end
        if (adv2 && v1_reg) begin
            word2_reg <= alu_out;
            last2_reg <= pos1_reg.last_word;
            end2_reg <= pos1_reg.blit_end;
        end
    end

    assign m_tvalid = v2_reg;
    assign m_tdata = word2_reg;
    assign m_tlast = last2_reg;
    assign m_tuser = end2_reg;

endmodule

[rtl/pbw_walk.sv]
// Word / line / plane walker: tracks the position of the next word and derives
// its edge limits and end flags. Depends on pbw_pkg.
module pbw_walk #(
    parameter int MAX_WIDTH = pbw_pkg::DEF_MAX_WIDTH,
    parameter int MAX_HEIGHT = pbw_pkg::DEF_MAX_HEIGHT,
    parameter int MAX_PLANES = pbw_pkg::DEF_MAX_PLANES
) (
    input  logic           aclk,
    input  logic           aresetn,
    input  pbw_pkg::cfg_t  cfg,
    input  logic           step,
    output pbw_pkg::pos_t  pos
);
    localparam int MAX_WORDS = (MAX_WIDTH + 30) / 16;
    localparam int WIX = (MAX_WORDS > 1) ? $clog2(MAX_WORDS) : 1;
    localparam int LIX = (MAX_HEIGHT > 1) ? $clog2(MAX_HEIGHT) : 1;
    localparam int PIX = (MAX_PLANES > 1) ? $clog2(MAX_PLANES) : 1;
    localparam int WCW = $clog2(MAX_WIDTH + 1);
    localparam int HCW = $clog2(MAX_HEIGHT + 1);
    localparam int PCW = $clog2(MAX_PLANES + 1);
    localparam int SPW = $clog2(MAX_WIDTH + 31);
    localparam int NW = SPW - 4;

    logic [WIX-1:0] word_reg, word_next;
    logic [LIX-1:0] line_reg, line_next;
    logic [PIX-1:0] plane_reg, plane_next;

    logic [WCW-1:0] w_clamped;
    logic [HCW-1:0] h_clamped, h_m1;
    logic [PCW-1:0] p_clamped, p_m1;
    logic [SPW-1:0] span_up;
    logic [NW-1:0]  nwords;
    logic [3:0]     span_rem;
    logic           last_word, last_line, last_plane;

    always_comb begin
        if (cfg.width == '0) begin
            w_clamped = WCW'(1);
        end else if (cfg.width > MAX_WIDTH) begin
            w_clamped = WCW'(MAX_WIDTH);
        end else begin
            w_clamped = WCW'(cfg.width);
        end
        if (cfg.height == '0) begin
            h_clamped = HCW'(1);
        end else if (cfg.height > MAX_HEIGHT) begin
            h_clamped = HCW'(MAX_HEIGHT);
        end else begin
            h_clamped = HCW'(cfg.height);
        end
        if (cfg.planes == '0) begin
            p_clamped = PCW'(1);
        end else if (cfg.planes > MAX_PLANES) begin
            p_clamped = PCW'(MAX_PLANES);
        end else begin
            p_clamped = PCW'(cfg.planes);
        end
    end

    assign h_m1 = h_clamped - HCW'(1);
    assign p_m1 = p_clamped - PCW'(1);

    // Round (width + dst offset) up to whole words
    assign span_up = SPW'(w_clamped) + SPW'(cfg.dst_offset) + SPW'(15);
    assign nwords = span_up[SPW-1:4];
    assign span_rem = w_clamped[3:0] + cfg.dst_offset;

    assign last_word = ((WIX + 1)'(word_reg) + (WIX + 1)'(1)) >= nwords;
    assign last_line = line_reg >= h_m1;
    assign last_plane = plane_reg >= p_m1;

    always_comb begin
        pos.start = (word_reg == '0) ? cfg.dst_offset : 4'd0;
        pos.stop = (last_word && span_rem != 4'd0) ? {1'b0, span_rem} : 5'd16;
        pos.last_word = last_word;
        pos.blit_end = last_word && last_line && last_plane;
    end

    always_comb begin
        word_next = word_reg;
        line_next = line_reg;
        plane_next = plane_reg;
        if (step) begin
            if (!last_word) begin
                word_next = word_reg + WIX'(1);
            end else begin
                word_next = '0;
                if (!last_line) begin
                    line_next = line_reg + LIX'(1);
                end else begin
                    line_next = '0;
                    plane_next = last_plane ? '0 : plane_reg + PIX'(1);
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            word_reg <= '0;
            line_reg <= '0;
            plane_reg <= '0;
        end else begin
            word_reg <= word_next;
            line_reg <= line_next;
            plane_reg <= plane_next;
        end
    end

endmodule

[rtl/pbw_word_alu.sv]
// Word datapath: funnel shift of the source, raster op and edge-mask merge.
// Purely combinational; depends on pbw_pkg.
module pbw_word_alu (
    input  logic                            msb_first,
    input  logic [2:0]                      rop,
    input  logic [3:0]                      src_offset,
    input  logic [3:0]                      dst_offset,
    input  logic [3:0]                      start,
    input  logic [4:0]                      stop,
    input  logic [pbw_pkg::WORD_BITS-1:0]   src_word,
    input  logic [pbw_pkg::WORD_BITS-1:0]   src_next_word,
    input  logic [pbw_pkg::WORD_BITS-1:0]   dest_word,
    output logic [pbw_pkg::WORD_BITS-1:0]   new_dest_word
);
    logic [3:0]                         shamt;
    logic [2*pbw_pkg::WORD_BITS-1:0]    cat_r, cat_l;
    logic [pbw_pkg::WORD_BITS-1:0]      src_al, rop_out, mask;

    assign shamt = src_offset - dst_offset;
    assign cat_r = {src_word, src_next_word} << shamt;
    assign cat_l = {src_next_word, src_word} >> shamt;
    assign src_al = msb_first ? cat_r[2*pbw_pkg::WORD_BITS-1:pbw_pkg::WORD_BITS]
                              : cat_l[pbw_pkg::WORD_BITS-1:0];

    always_comb begin
        case (rop)
            pbw_pkg::ROP_COPY:    rop_out = src_al;
            pbw_pkg::ROP_NOT:     rop_out = ~src_al;
            pbw_pkg::ROP_AND:     rop_out = dest_word & src_al;
            pbw_pkg::ROP_AND_NOT: rop_out = dest_word & ~src_al;
            pbw_pkg::ROP_OR:      rop_out = dest_word | src_al;
            pbw_pkg::ROP_OR_NOT:  rop_out = dest_word | ~src_al;
            pbw_pkg::ROP_XOR:     rop_out = dest_word ^ src_al;
            default:              rop_out = dest_word ^ ~src_al;
        endcase
    end

    // Pixel p sits at bit p, or at bit 15-p when msb_first is set
    always_comb begin
        logic [3:0] pix;
        pix = '0;
        for (int i = 0; i < pbw_pkg::WORD_BITS; i++) begin
            pix = msb_first ? 4'(pbw_pkg::WORD_BITS - 1 - i) : 4'(i);
            mask[i] = (pix >= start) && ({1'b0, pix} < stop);
        end
    end

    assign new_dest_word = (dest_word & ~mask) | (rop_out & mask);

endmodule

[rtl/pbw_checker.sv]
// Port-level checker for planar_bitblt_word_engine, attached by bind.
// Depends only on the top level's ports.
module pbw_checker (
    input logic        aclk,
    input logic        aresetn,
    input logic        s_tvalid,
    input logic        s_tready,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [15:0] m_tdata,
    input logic        m_tlast,
    input logic        m_tuser
);

    // Hold a stalled result
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata)
            && $stable(m_tlast) && $stable(m_tuser))
        else $error("stalled result changed");

    a_end_is_line_end: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tuser |-> m_tlast)
        else $error("blit end without line end");

    // No input transfer during reset; no result right after it
    a_reset_clears: assert property (@(posedge aclk)
        !aresetn |-> !s_tready ##1 !m_tvalid)
        else $error("valid or ready after reset");

    a_rise_has_source: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_tvalid) |-> $past(s_tvalid && s_tready, 2))
        else $error("result without an input transfer two cycles earlier");

endmodule

bind planar_bitblt_word_engine pbw_checker u_pbw_checker (
    .aclk    (aclk),
    .aresetn (aresetn),
    .s_tvalid(s_tvalid),
    .s_tready(s_tready),
    .m_tvalid(m_tvalid),
    .m_tready(m_tready),
    .m_tdata (m_tdata),
    .m_tlast (m_tlast),
    .m_tuser (m_tuser)
);
